[src/bsc_pkg.sv]
// shared types and codes for the banker's safety checker
package bsc_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD_AVAIL = 3'd0,
    CMD_LOAD_MAX   = 3'd1,
    CMD_LOAD_ALLOC = 3'd2,
    CMD_CHECK      = 3'd3,
    CMD_REQUEST    = 3'd4
  } cmd_t;

  localparam logic [2:0] ST_LOADED      = 3'd0;
  localparam logic [2:0] ST_SAFE        = 3'd1;
  localparam logic [2:0] ST_UNSAFE      = 3'd2;
  localparam logic [2:0] ST_GRANTED     = 3'd3;
  localparam logic [2:0] ST_DENIED      = 3'd4;
  localparam logic [2:0] ST_DENY_UNSAFE = 3'd5;
  localparam logic [2:0] ST_INVALID     = 3'd6;

  localparam logic REG_PROCS = 1'b0;
  localparam logic REG_RES   = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  proc_index;
    logic [1:0]  res_index;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] done_proc;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_ADD,
    S_VERDICT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture command beat
    logic apply;     // perform load / set up scan
    logic start_scan;
    logic next_res;  // step resource counter during compare
    logic add_res;   // step resource counter during release
    logic finish_proc;
    logic next_proc;
    logic new_pass;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_scan;    // command runs a scan
    logic res_last;   // resource counter at last active resource
    logic fits_now;   // current resource fits
    logic proc_done;  // current process already finished
    logic proc_last;  // proc counter at last active process
    logic all_done;
    logic progress;
  } dp_stat_t;

endpackage

[src/bsc_ctrl.sv]
// controller state machine sequencing the safety scan
module bsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bsc_pkg::dp_stat_t  stat,
  output bsc_pkg::dp_cmd_t   cmd,
  output logic               emit_proc,
  output logic               emit_verdict
);

  bsc_pkg::state_t state_r, state_nxt;
  logic fit_r, fit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsc_pkg::S_IDLE;
      fit_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      fit_r   <= fit_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fit_nxt      = fit_r;
    cmd          = '0;
    emit_proc    = 1'b0;
    emit_verdict = 1'b0;
    busy         = (state_r != bsc_pkg::S_IDLE);
    unique case (state_r)
      bsc_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = bsc_pkg::S_DECIDE;
        end
      end
      bsc_pkg::S_DECIDE: begin
        cmd.apply = 1'b1;
        if (stat.is_scan) begin
          cmd.start_scan = 1'b1;
          fit_nxt        = 1'b1;
          state_nxt      = bsc_pkg::S_SCAN;
        end else begin
          emit_verdict = 1'b1;
          state_nxt    = bsc_pkg::S_IDLE;
        end
      end
      bsc_pkg::S_SCAN: begin
        // one resource compared per cycle
        if (stat.all_done) begin
          state_nxt = bsc_pkg::S_VERDICT;
        end else if (stat.proc_done || !(fit_r && stat.fits_now) || stat.res_last) begin
          if (!stat.proc_done && fit_r && stat.fits_now) begin
            cmd.finish_proc = 1'b1;
            emit_proc       = 1'b1;
            state_nxt       = bsc_pkg::S_ADD;
          end else if (stat.proc_last) begin
            if (stat.progress) begin
              cmd.new_pass = 1'b1;
            end else begin
              state_nxt = bsc_pkg::S_VERDICT;
            end
          end else begin
            cmd.next_proc = 1'b1;
          end
          fit_nxt = 1'b1;
        end else begin
          cmd.next_res = 1'b1;
        end
      end
      bsc_pkg::S_ADD: begin
        cmd.add_res = 1'b1;
        if (stat.res_last) begin
          state_nxt = bsc_pkg::S_SCAN;
          if (stat.all_done) begin
            state_nxt = bsc_pkg::S_VERDICT;
          end else if (stat.proc_last) begin
            cmd.new_pass = 1'b1;
          end else begin
            cmd.next_proc = 1'b1;
          end
        end
      end
      bsc_pkg::S_VERDICT: begin
        emit_verdict = 1'b1;
        state_nxt    = bsc_pkg::S_IDLE;
      end
      default: state_nxt = bsc_pkg::S_IDLE;
    endcase
  end

  a_verdict_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    emit_verdict |-> (state_r == bsc_pkg::S_DECIDE || state_r == bsc_pkg::S_VERDICT))
    else $error("verdict outside decide/verdict");
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(emit_proc && emit_verdict)) else $error("two results in one cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == bsc_pkg::S_DECIDE))
    else $error("accepted beat not decoded");

endmodule

[src/bsc_dp.sv]
// datapath: stores, work vector, what-if request registers and scan counters
module bsc_dp #(
  parameter int MAX_PROCS   = 8,
  parameter int MAX_RES     = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bsc_pkg::in_item_t   in_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  bsc_pkg::dp_cmd_t    cmd,
  output bsc_pkg::dp_stat_t   stat,
  output logic [2:0]          cur_proc,
  output logic [2:0]          verdict
);

  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int WW = COUNT_WIDTH + 4;
  localparam int NE = MAX_PROCS * MAX_RES;
  localparam logic [WW-1:0] WORK_MAX = {WW{1'b1}};

  logic [3:0] procs_r;
  logic [2:0] res_r;
  bsc_pkg::in_item_t item_r;

  logic [COUNT_WIDTH-1:0] avail_r [MAX_RES];
  logic [COUNT_WIDTH-1:0] max_r   [NE];
  logic [COUNT_WIDTH-1:0] alloc_r [NE];
  logic [COUNT_WIDTH-1:0] need_r  [NE];
  logic [WW-1:0]          work_r  [MAX_RES];
  logic [MAX_PROCS-1:0]   fin_r;
  logic [PW-1:0]          p_r;
  logic [RW-1:0]          r_r;
  logic [PW:0]            done_r;
  logic                   prog_r;
  logic                   req_r;      // scan applies the request as a what-if
  logic [COUNT_WIDTH-1:0] req_amt_r;
  logic [PW-1:0]          req_p_r;
  logic [RW-1:0]          req_rs_r;

  // effective counts
  logic [PW:0] np;
  logic [RW:0] nr;
  always_comb begin
    if (procs_r == 4'd0) np = (PW+1)'(1);
    else if (32'(procs_r) > MAX_PROCS) np = (PW+1)'(MAX_PROCS);
    else np = (PW+1)'(procs_r);
    if (res_r == 3'd0) nr = (RW+1)'(1);
    else if (32'(res_r) > MAX_RES) nr = (RW+1)'(MAX_RES);
    else nr = (RW+1)'(res_r);
  end

  logic p_ok, r_ok;
  logic [PW+RW-1:0] idx;
  logic [COUNT_WIDTH-1:0] amt;
  assign p_ok = 32'(item_r.proc_index) < 32'(np);
  assign r_ok = 32'(item_r.res_index) < 32'(nr);
  assign idx  = (PW+RW)'(32'(item_r.proc_index) * MAX_RES + 32'(item_r.res_index));
  assign amt  = COUNT_WIDTH'(item_r.amount);

  // current scan element with what-if adjustment
  logic [PW+RW-1:0] sidx;
  logic hit;
  logic [COUNT_WIDTH-1:0] s_need, s_alloc;
  assign sidx   = {p_r, r_r} == '0 ? '0 : (PW+RW)'(32'(p_r) * MAX_RES + 32'(r_r));
  assign hit    = req_r && (p_r == req_p_r) && (r_r == req_rs_r);
  assign s_need  = hit ? need_r[sidx] - req_amt_r : need_r[sidx];
  assign s_alloc = hit ? alloc_r[sidx] + req_amt_r : alloc_r[sidx];

  logic [WW:0] sum;
  assign sum = {1'b0, work_r[r_r]} + (WW+1)'(s_alloc);

  assign stat.is_scan   = item_r.cmd == bsc_pkg::CMD_CHECK ||
                          (item_r.cmd == bsc_pkg::CMD_REQUEST && p_ok && r_ok &&
                           amt <= need_r[idx] &&
                           amt <= avail_r[(RW)'(item_r.res_index)]);
  assign stat.res_last  = 32'(r_r) == 32'(nr) - 1;
  assign stat.fits_now  = work_r[r_r] >= WW'(s_need);
  assign stat.proc_done = fin_r[p_r];
  assign stat.proc_last = 32'(p_r) == 32'(np) - 1;
  assign stat.all_done  = done_r >= np;
  assign stat.progress  = prog_r;
  assign cur_proc = 3'(p_r);

  // simple command status
  logic [2:0] sstat;
  always_comb begin
    sstat = bsc_pkg::ST_INVALID;
    unique case (item_r.cmd)
      bsc_pkg::CMD_LOAD_AVAIL: if (r_ok) sstat = bsc_pkg::ST_LOADED;
      bsc_pkg::CMD_LOAD_MAX:
        if (p_ok && r_ok && amt >= alloc_r[idx]) sstat = bsc_pkg::ST_LOADED;
      bsc_pkg::CMD_LOAD_ALLOC:
        if (p_ok && r_ok && amt <= max_r[idx]) sstat = bsc_pkg::ST_LOADED;
      bsc_pkg::CMD_REQUEST: if (p_ok && r_ok) sstat = bsc_pkg::ST_DENIED;
      default: sstat = bsc_pkg::ST_INVALID;
    endcase
  end

  // one-beat commands report in the decode cycle, scans at their end
  always_comb begin
    if (req_r) verdict = stat.all_done ? bsc_pkg::ST_GRANTED : bsc_pkg::ST_DENY_UNSAFE;
    else verdict = stat.all_done ? bsc_pkg::ST_SAFE : bsc_pkg::ST_UNSAFE;
    if (cmd.apply) verdict = sstat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      procs_r <= 4'd8;
      res_r   <= 3'd4;
      for (int i = 0; i < MAX_RES; i++) begin
        avail_r[i] <= '0;
        work_r[i]  <= '0;
      end
      for (int i = 0; i < NE; i++) begin
        max_r[i]   <= '0;
        alloc_r[i] <= '0;
        need_r[i]  <= '0;
      end
      fin_r <= '0; p_r <= '0; r_r <= '0; done_r <= '0;
      prog_r <= 1'b0; req_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bsc_pkg::REG_PROCS) procs_r <= cfg_data[3:0];
        else res_r <= cfg_data[2:0];
      end
      if (cmd.latch) item_r <= in_item;
      if (cmd.apply) begin
        if (sstat == bsc_pkg::ST_LOADED) begin
          unique case (item_r.cmd)
            bsc_pkg::CMD_LOAD_AVAIL: avail_r[RW'(item_r.res_index)] <= amt;
            bsc_pkg::CMD_LOAD_MAX: begin
              max_r[idx]  <= amt;
              need_r[idx] <= amt - alloc_r[idx];
            end
            default: begin
              alloc_r[idx] <= amt;
              need_r[idx]  <= max_r[idx] - amt;
            end
          endcase
        end
      end
      if (cmd.start_scan) begin
        req_r     <= item_r.cmd == bsc_pkg::CMD_REQUEST;
        req_amt_r <= amt;
        req_p_r   <= PW'(item_r.proc_index);
        req_rs_r  <= RW'(item_r.res_index);
        for (int i = 0; i < MAX_RES; i++) begin
          if (item_r.cmd == bsc_pkg::CMD_REQUEST && i == 32'(item_r.res_index))
            work_r[i] <= WW'(avail_r[i] - amt);
          else
            work_r[i] <= WW'(avail_r[i]);
        end
        fin_r <= '0; p_r <= '0; done_r <= '0; prog_r <= 1'b0;
      end
      if (cmd.start_scan || cmd.finish_proc || cmd.next_proc || cmd.new_pass) begin
        r_r <= '0;
      end else if (cmd.next_res || cmd.add_res) begin
        r_r <= r_r + 1'b1;
      end
      if (cmd.finish_proc) begin
        fin_r[p_r] <= 1'b1;
        done_r     <= done_r + 1'b1;
        prog_r     <= 1'b1;
      end
      if (cmd.add_res) begin
        work_r[r_r] <= sum > (WW+1)'(WORK_MAX) ? WORK_MAX : sum[WW-1:0];
      end
      if (cmd.next_proc) begin
        p_r <= p_r + 1'b1;
      end
      if (cmd.new_pass) begin
        p_r <= '0; prog_r <= 1'b0;
      end
    end
  end

  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r <= (PW+1)'(MAX_PROCS)) else $error("completion count overflow");
  a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish_proc |-> !fin_r[p_r]) else $error("process finished twice");
  a_proc_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(p_r) < MAX_PROCS) else $error("process counter out of range");

endmodule

[src/bankers_safety_checker.sv]
// top level: banker's algorithm safety checker, command in, results out
// loads, invalid commands and out-of-bounds requests report their verdict from decode
// check/request: up to np passes of np processes, one resource compare a cycle,
//   then a release step per resource for each finished process, then the verdict
// one item at a time; busy stays high until the verdict beat
// rst_n synchronous: stores zeroed, procs_in_use 8, res_in_use 4
module bankers_safety_checker #(
  parameter int MAX_PROCS   = 8,
  parameter int MAX_RES     = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bsc_pkg::in_item_t  in_item,
  output logic               out_valid,
  output bsc_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  bsc_pkg::dp_cmd_t  dcmd;
  bsc_pkg::dp_stat_t dstat;
  logic emit_proc, emit_verdict;
  logic [2:0] cur_proc, verdict;

  assign cfg_ready = 1'b1;

  bsc_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy,
    .stat(dstat), .cmd(dcmd), .emit_proc, .emit_verdict
  );

  bsc_dp #(.MAX_PROCS(MAX_PROCS), .MAX_RES(MAX_RES), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk, .rst_n, .in_item,
    .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .cmd(dcmd), .stat(dstat), .cur_proc, .verdict
  );

  bsc_pkg::out_item_t out_r, out_nxt;
  logic valid_r;

  always_comb begin
    out_nxt = '0;
    if (emit_verdict) begin
      out_nxt.kind   = 1'b1;
      out_nxt.status = verdict;
      out_nxt.last   = 1'b1;
    end else begin
      out_nxt.done_proc = cur_proc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= emit_proc || emit_verdict;
    out_r <= out_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = out_r;

endmodule
